// ===== design/rdc_pkg.sv =====
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types, widths and helpers of the radix digit converter.
// ----------------------------------------------------------------------------
package rdc_pkg;

    localparam int VALUE_W     = 32;
    localparam int RADIX_W     = 5;
    localparam int DIGIT_W     = 4;
    localparam int TOP_W       = 5;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;
    localparam int BYTE_W      = 8;
    localparam int STEPS_W     = 2;

    localparam logic [RADIX_W-1:0]  RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0]  RADIX_MAX   = 5'd16;
    localparam logic [RADIX_W-1:0]  RADIX_RESET = 5'd2;
    localparam logic [STEPS_W-1:0]  LAST_STEP   = 2'd3;

    // Register word addresses on the configuration port.
    localparam logic REG_RADIX = 1'b0;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
        logic               zero;
    } cmd_t;

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_MIN)
        begin
            res = RADIX_MIN;
        end
        else if (r > RADIX_MAX)
        begin
            res = RADIX_MAX;
        end
        return res;
    endfunction

endpackage

// ===== design/rdc_front.sv =====
// ----------------------------------------------------------------------------
// rdc_front
// Configuration register, input acceptance and classification of each value.
// ----------------------------------------------------------------------------
module rdc_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rdc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [rdc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rdc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            push,
    output logic                            full,
    input  logic [rdc_pkg::VALUE_W-1:0]     value,
    output logic                            q_push,
    output rdc_pkg::cmd_t                   q_cmd,
    input  logic                            q_full
);
    import rdc_pkg::*;

    logic [RADIX_W-1:0] radix_reg;
    logic [RADIX_W-1:0] radix_next;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[APB_ADDR_W-1] == REG_RADIX);

    always_comb
    begin
        radix_next = radix_reg;
        if (cfg_write)
        begin
            radix_next = pwdata[RADIX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else
        begin
            radix_reg <= radix_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[APB_ADDR_W-1] == REG_RADIX)
        begin
            prdata = APB_DATA_W'(radix_reg);
        end
    end

    assign full         = q_full;
    assign q_push       = push && !q_full;
    assign q_cmd.value  = value;
    assign q_cmd.radix  = clamp_radix(radix_reg);
    assign q_cmd.zero   = (value == '0);

endmodule

// ===== design/rdc_queue.sv =====
// ----------------------------------------------------------------------------
// rdc_queue
// Two-entry command queue between the front and the conversion engine.
// ----------------------------------------------------------------------------
module rdc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  rdc_pkg::cmd_t wr_cmd,
    output logic          q_full,
    input  logic          rd_en,
    output rdc_pkg::cmd_t rd_cmd,
    output logic          q_empty
);
    import rdc_pkg::*;

    cmd_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               do_wr;
    logic               do_rd;

    assign q_full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_cmd  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// ===== design/rdc_back.sv =====
// ----------------------------------------------------------------------------
// rdc_back
// Conversion engine: repeated division eight bits a cycle, digit store, and
// emission of the digits most significant first through an output register.
// ----------------------------------------------------------------------------
module rdc_back #(
    parameter int MAX_DIGITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rdc_pkg::cmd_t               q_cmd,
    input  logic                        q_empty,
    output logic                        q_pop,
    output logic                        empty,
    input  logic                        pop,
    output logic [rdc_pkg::DIGIT_W-1:0] digit,
    output logic [rdc_pkg::TOP_W-1:0]   top_index,
    output logic                        last
);
    import rdc_pkg::*;

    localparam int ADDR_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]          state_reg,   state_next;
    logic [VALUE_W-1:0]  work_reg,    work_next;
    logic [DIGIT_W-1:0]  rem_reg,     rem_next;
    logic [RADIX_W-1:0]  radix_reg,   radix_next;
    logic [STEPS_W-1:0]  step_reg,    step_next;
    logic [CNT_W-1:0]    cnt_reg,     cnt_next;
    logic [ADDR_W-1:0]   rd_ptr_reg,  rd_ptr_next;
    logic [TOP_W-1:0]    top_reg,     top_next;
    logic                rd_valid_reg, rd_valid_next;
    logic [TOP_W-1:0]    rd_top_reg,  rd_top_next;
    logic                rd_last_reg, rd_last_next;
    logic [DIGIT_W-1:0]  rd_data_reg;
    logic                out_valid_reg, out_valid_next;
    logic [DIGIT_W-1:0]  out_digit_reg, out_digit_next;
    logic [TOP_W-1:0]    out_top_reg,   out_top_next;
    logic                out_last_reg,  out_last_next;

    logic [DIGIT_W-1:0]  digit_mem [MAX_DIGITS];
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [DIGIT_W-1:0]  mem_wdata;
    logic                rd_issue;
    logic                out_load;

    logic [BYTE_W-1:0]   q_byte;
    logic [DIGIT_W-1:0]  step_rem;
    logic [VALUE_W-1:0]  shifted;
    logic [CNT_W-1:0]    cnt_inc;

    // Long division of one byte by the radix, remainder carried in.
    always_comb
    begin
        logic [RADIX_W-1:0] t;
        logic [DIGIT_W-1:0] r;
        r = rem_reg;
        q_byte = '0;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            t = {r, work_reg[VALUE_W-BYTE_W+i]};
            if (t >= radix_reg)
            begin
                t = t - radix_reg;
                q_byte[i] = 1'b1;
            end
            r = t[DIGIT_W-1:0];
        end
        step_rem = r;
    end

    assign shifted  = {work_reg[VALUE_W-BYTE_W-1:0], q_byte};
    assign cnt_inc  = cnt_reg + 1'b1;
    assign out_load = rd_valid_reg && (!out_valid_reg || pop);
    assign rd_issue = (state_reg == ST_EMIT) && (!rd_valid_reg || out_load);
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;

    always_comb
    begin
        state_next  = state_reg;
        work_next   = work_reg;
        rem_next    = rem_reg;
        radix_next  = radix_reg;
        step_next   = step_reg;
        cnt_next    = cnt_reg;
        rd_ptr_next = rd_ptr_reg;
        top_next    = top_reg;
        mem_we      = 1'b0;
        mem_waddr   = cnt_reg[ADDR_W-1:0];
        mem_wdata   = step_rem;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    work_next  = q_cmd.value;
                    radix_next = q_cmd.radix;
                    rem_next   = '0;
                    step_next  = '0;
                    cnt_next   = '0;
                    if (q_cmd.zero)
                    begin
                        mem_we      = 1'b1;
                        mem_waddr   = '0;
                        mem_wdata   = '0;
                        cnt_next    = CNT_W'(1);
                        rd_ptr_next = '0;
                        top_next    = '0;
                        state_next  = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                work_next = shifted;
                rem_next  = step_rem;
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    mem_we   = 1'b1;
                    rem_next = '0;
                    cnt_next = cnt_inc;
                    if ((shifted == '0) || (cnt_inc == CNT_W'(MAX_DIGITS)))
                    begin
                        rd_ptr_next = cnt_reg[ADDR_W-1:0];
                        top_next    = TOP_W'(cnt_reg);
                        state_next  = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (rd_issue)
                begin
                    rd_ptr_next = rd_ptr_reg - 1'b1;
                    if (rd_ptr_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rd_valid_next = rd_valid_reg;
        rd_top_next   = rd_top_reg;
        rd_last_next  = rd_last_reg;
        if (rd_issue)
        begin
            rd_valid_next = 1'b1;
            rd_top_next   = top_reg;
            rd_last_next  = (rd_ptr_reg == '0);
        end
        else if (out_load)
        begin
            rd_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        out_digit_next = out_digit_reg;
        out_top_next   = out_top_reg;
        out_last_next  = out_last_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_digit_next = rd_data_reg;
            out_top_next   = rd_top_reg;
            out_last_next  = rd_last_reg;
        end
        else if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            work_reg      <= '0;
            cnt_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            work_reg      <= work_next;
            cnt_reg       <= cnt_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        radix_reg     <= radix_next;
        step_reg      <= step_next;
        rd_ptr_reg    <= rd_ptr_next;
        top_reg       <= top_next;
        rd_top_reg    <= rd_top_next;
        rd_last_reg   <= rd_last_next;
        out_digit_reg <= out_digit_next;
        out_top_reg   <= out_top_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            digit_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_issue)
        begin
            rd_data_reg <= digit_mem[rd_ptr_reg];
        end
    end

    assign empty     = !out_valid_reg;
    assign digit     = out_digit_reg;
    assign top_index = out_top_reg;
    assign last      = out_last_reg;

endmodule

// ===== design/radix_digit_converter.sv =====
// ----------------------------------------------------------------------------
// radix_digit_converter
// Converts a 32-bit unsigned value into digits of the configured radix,
// emitted most significant digit first.
//
//   Channel   Handshake              Payload
//   config    psel/penable/pready    paddr, pwdata, prdata (radix at 0)
//   input     push / full            value
//   result    empty / pop            digit, top_index, last
//
// A value leaves the queue, and the divider then finds each digit as the
// remainder of the value over the radix, eight quotient bits a cycle; a zero
// value skips the divider. The emitter sends the stored digits out.
// Two further values can wait in the queue.
// Reset sets the radix to 2 and empties the queue and output register.
// A stalled result holds the emitter, and the next value waits in the queue
// until the last digit of the current one has been read from the store.
// ----------------------------------------------------------------------------
module radix_digit_converter #(
    parameter int MAX_DIGITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rdc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [rdc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rdc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            push,
    output logic                            full,
    input  logic [rdc_pkg::VALUE_W-1:0]     value,
    output logic                            empty,
    input  logic                            pop,
    output logic [rdc_pkg::DIGIT_W-1:0]     digit,
    output logic [rdc_pkg::TOP_W-1:0]       top_index,
    output logic                            last
);
    import rdc_pkg::*;

    cmd_t q_in_cmd;
    cmd_t q_out_cmd;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;

    rdc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .push    (push),
        .full    (full),
        .value   (value),
        .q_push  (q_push),
        .q_cmd   (q_in_cmd),
        .q_full  (q_full)
    );

    rdc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_cmd  (q_in_cmd),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_cmd  (q_out_cmd),
        .q_empty (q_empty)
    );

    rdc_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_cmd     (q_out_cmd),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .digit     (digit),
        .top_index (top_index),
        .last      (last)
    );

endmodule

// ===== sim/radix_digit_converter_checker.sv =====
// ----------------------------------------------------------------------------
// radix_digit_converter_checker
// Watches the configuration, request and result channels of the radix digit
// converter. It keeps its own copy of the radix register and, for every
// accepted request, divides the value down into digits. It then checks each
// popped result, field by field, against the oldest digit still due.
// ----------------------------------------------------------------------------
module radix_digit_converter_checker #(
    parameter int MAX_DIGITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rdc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [rdc_pkg::APB_DATA_W-1:0]  pwdata,
    input  logic                            pready,
    input  logic                            push,
    input  logic                            full,
    input  logic [rdc_pkg::VALUE_W-1:0]     value,
    input  logic                            empty,
    input  logic                            pop,
    input  logic [rdc_pkg::DIGIT_W-1:0]     digit,
    input  logic [rdc_pkg::TOP_W-1:0]       top_index,
    input  logic                            last,
    output int                              errors,
    output int                              pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import rdc_pkg::*;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic [TOP_W-1:0]   top;
        logic               last;
    } digit_result_t;

    digit_result_t      digits_due [$];
    logic [RADIX_W-1:0] radix_setting = RADIX_RESET;
    int                 mismatch_count = 0;
    int                 due_count = 0;

    assign errors  = mismatch_count;
    assign pending = due_count;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic void predict_digits(input logic [VALUE_W-1:0] number);
        logic [RADIX_W-1:0] base;
        logic [VALUE_W-1:0] quotient;
        logic [DIGIT_W-1:0] remainders [MAX_DIGITS];
        int                 count;
        digit_result_t      rec;
        base = radix_setting;
        if (base < RADIX_MIN)
        begin
            base = RADIX_MIN;
        end
        else if (base > RADIX_MAX)
        begin
            base = RADIX_MAX;
        end
        quotient = number;
        count = 0;
        do
        begin
            remainders[count] = DIGIT_W'(quotient % base);
            quotient = quotient / base;
            count++;
        end
        while (quotient != 0 && count < MAX_DIGITS);
        for (int k = count - 1; k >= 0; k--)
        begin
            rec.digit = remainders[k];
            rec.top   = TOP_W'(count - 1);
            rec.last  = (k == 0);
            digits_due.push_back(rec);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        digit_result_t want;
        if (!rst_n)
        begin
            radix_setting = RADIX_RESET;
            digits_due.delete();
            due_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[APB_ADDR_W-1:2] == REG_RADIX)
            begin
                radix_setting = pwdata[RADIX_W-1:0];
            end
            if (pop && !empty)
            begin
                if (digits_due.size() == 0)
                begin
                    report_mismatch($sformatf("result with no digit due: digit %0d top %0d last %0b",
                                              digit, top_index, last));
                end
                else
                begin
                    want = digits_due.pop_front();
                    if (digit !== want.digit)
                    begin
                        report_mismatch($sformatf("digit mismatch: expected %0d, got %0d",
                                                  want.digit, digit));
                    end
                    if (top_index !== want.top)
                    begin
                        report_mismatch($sformatf("top_index mismatch: expected %0d, got %0d",
                                                  want.top, top_index));
                    end
                    if (last !== want.last)
                    begin
                        report_mismatch($sformatf("last mismatch: expected %0b, got %0b",
                                                  want.last, last));
                    end
                end
            end
            if (push && !full)
            begin
                predict_digits(value);
            end
            due_count = digits_due.size();
        end
    end

endmodule

// ===== sim/radix_digit_converter_test.sv =====
// ----------------------------------------------------------------------------
// radix_digit_converter_test
// Drives the radix digit converter through directed and random requests
// under a range of radix settings, including out-of-range ones, with random
// gaps on both the request and result sides. The checker beside the block
// predicts and compares every digit; this module gives the verdict.
// ----------------------------------------------------------------------------
module radix_digit_converter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rdc_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 6;
    localparam int MAX_GAP      = 19;
    localparam int DRAIN_CYCLES = 200;
    localparam int STALL_LIMIT  = 4000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 36;

    localparam logic [APB_ADDR_W-1:0] RADIX_ADDR  = {REG_RADIX, 2'b00};
    localparam logic [APB_ADDR_W-1:0] UNUSED_ADDR = {~REG_RADIX, 2'b00};

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   push = 1'b0;
    logic                   full;
    logic [VALUE_W-1:0]     value = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic [DIGIT_W-1:0]     digit;
    logic [TOP_W-1:0]       top_index;
    logic                   last;
    int                     errors;
    int                     pending;
    bit                     send_quiet = 1'b0;
    bit                     pop_quiet = 1'b0;
    int                     stall_cycles = 0;

    radix_digit_converter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .push      (push),
        .full      (full),
        .value     (value),
        .empty     (empty),
        .pop       (pop),
        .digit     (digit),
        .top_index (top_index),
        .last      (last)
    );

    radix_digit_converter_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pready    (pready),
        .push      (push),
        .full      (full),
        .value     (value),
        .empty     (empty),
        .pop       (pop),
        .digit     (digit),
        .top_index (top_index),
        .last      (last),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // All tasks start and end at a falling edge.
    task automatic offer_value(input logic [VALUE_W-1:0] number);
        int gap;
        bit blocked;
        gap = send_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push  <= 1'b1;
        value <= number;
        do
        begin
            blocked = full;
            @(negedge clk);
        end
        while (blocked);
    endtask

    task automatic drain_converter();
        push <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [APB_ADDR_W-1:0] addr,
                                  input logic [RADIX_W-1:0] setting);
        logic [APB_DATA_W-1:0] data;
        drain_converter();
        data = $urandom;
        data[RADIX_W-1:0] = setting;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        int gap;
        bit waiting;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            gap = pop_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (gap != 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            pop <= 1'b1;
            do
            begin
                waiting = empty;
                @(negedge clk);
            end
            while (waiting);
        end
    end

    initial
    begin
        logic [VALUE_W-1:0] number;
        logic [RADIX_W-1:0] setting;
        int                 kind;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        offer_value(32'd0);
        offer_value(32'd1);
        offer_value(32'hFFFF_FFFF);
        offer_value(32'h8000_0000);
        offer_value(32'h5555_5555);

        write_register(RADIX_ADDR, RADIX_MAX);
        offer_value(32'd0);
        offer_value(32'd15);
        offer_value(32'd16);
        offer_value(32'hFFFF_FFFF);
        offer_value(32'h0123_4567);

        write_register(RADIX_ADDR, 5'd0);
        offer_value(32'd5);
        offer_value(32'hFFFF_FFFF);
        write_register(RADIX_ADDR, 5'd1);
        offer_value(32'd6);
        write_register(RADIX_ADDR, 5'd31);
        offer_value(32'hDEAD_BEEF);
        offer_value(32'd255);
        write_register(UNUSED_ADDR, 5'd10);
        offer_value(32'd100);
        write_register(RADIX_ADDR, 5'd17);
        offer_value(32'hABCD_EF01);
        write_register(RADIX_ADDR, 5'd10);
        offer_value(32'hFFFF_FFFF);
        offer_value(32'd1_000_000_000);
        offer_value(32'd999_999_999);
        write_register(RADIX_ADDR, 5'd3);
        offer_value(32'hFFFF_FFFF);
        offer_value(32'd2);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 0)
            begin
                setting = RADIX_MIN;
            end
            else if (phase == 1)
            begin
                setting = RADIX_MAX;
            end
            else if ($urandom_range(0, 3) != 0)
            begin
                setting = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
            end
            else
            begin
                setting = RADIX_W'($urandom_range(0, 31));
            end
            write_register(RADIX_ADDR, setting);
            if (phase == 5)
            begin
                write_register(UNUSED_ADDR, RADIX_W'($urandom_range(0, 31)));
            end
            send_quiet = (phase % 3 == 0);
            pop_quiet  = (phase % 4 == 1);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                kind = $urandom_range(0, 9);
                if (kind == 0)
                begin
                    number = '0;
                end
                else if (kind == 1)
                begin
                    number = '1;
                end
                else if (kind < 5)
                begin
                    number = $urandom_range(0, 255);
                end
                else
                begin
                    number = $urandom >> $urandom_range(0, 31);
                end
                offer_value(number);
            end
        end

        drain_converter();
        if (errors == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
